FILE: hw/rtl/nearest_neighbor_frame_scaler_defines.svh
// Assertion macros for the nearest neighbour frame scaler.
// Included by files that carry concurrent checks; needs a clock and a reset in scope.
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_DEFINES_SVH
`ifndef SYNTHESIS
// condition holds -> expression holds in the same cycle
`define NNFS_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("nnfs: same-cycle check failed");
// condition holds -> expression holds in the next cycle
`define NNFS_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("nnfs: next-cycle check failed");
`else
`define NNFS_ASSERT_NOW(label, cond, expr)
`define NNFS_ASSERT_NEXT(label, cond, expr)
`endif
`endif

FILE: hw/rtl/nnfs_pkg.sv
// Shared types and constants for the nearest neighbour frame scaler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package nnfs_pkg;

   // default output raster and fixed frame store geometry
   localparam int OUT_WIDTH_DEFAULT  = 1920;
   localparam int OUT_HEIGHT_DEFAULT = 1080;
   localparam int STORE_WIDTH        = 1920;
   localparam int STORE_HEIGHT       = 1080;
   localparam int STORE_DEPTH        = STORE_WIDTH * STORE_HEIGHT;

   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PIXEL_W     = 16;
   localparam int SIZE_W      = 11;
   localparam int COORD_W     = 12;  // widest output raster coordinate
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLIP_ROWS     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_TO_FILL = 2'd3;

   // beat kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   // live configuration, sizes already saturated
   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic              flip;
      logic              fill;
      logic [ADDR_W-1:0] area;
   } cfg_type;

   // one classified beat on its way from front to back
   typedef struct packed {
      logic               kind;
      logic [PIXEL_W-1:0] pixel;
      logic [ADDR_W-1:0]  load_addr;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic               flip;
      logic               fill;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hw/rtl/nearest_neighbor_frame_scaler.sv
// Nearest neighbour frame scaler, top level (uses nnfs_pkg, nnfs_csr, nnfs_front,
// nnfs_queue, nnfs_back). A beat with req_kind 0 writes req_pixel_in into the
// 1920x1080 frame store at the running load address, which wraps after
// source_width*source_height pixels; a beat with req_kind 1 asks for the next
// pixel of the OUT_WIDTH x OUT_HEIGHT output raster, walked in raster order, and
// yields one rsp beat, either nearest-neighbour scaled (scale_to_fill) or with the
// source centred unscaled and black around it, rows optionally mirrored. The front
// end takes a beat whenever its two-entry queue has room; the back end retires a
// load on its pop and runs a scanout beat through its sequencer (size products,
// reciprocal multiply, correction, selection, address product, registered store
// read, hand-over to the result register). The result register lets the next beats
// enter while a finished pixel waits. The store has no clearing pass: a pixel read
// before it was loaded is undefined. Sizes are saturated to 1..min(output size,
// store size); the user must write registers while the block is idle; not enforced.
`timescale 1ns / 1ps
`include "nearest_neighbor_frame_scaler_defines.svh"

module nearest_neighbor_frame_scaler #(
   parameter int OUT_WIDTH  = nnfs_pkg::OUT_WIDTH_DEFAULT,
   parameter int OUT_HEIGHT = nnfs_pkg::OUT_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [nnfs_pkg::PIXEL_W-1:0]     req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nnfs_pkg::SIZE_W-1:0]      rsp_out_col,
   output logic [nnfs_pkg::SIZE_W-1:0]      rsp_out_row,
   output logic [nnfs_pkg::PIXEL_W-1:0]     rsp_pixel_out,
   output logic                             rsp_frame_end,
   input  logic                             csr_wr_en,
   input  logic [nnfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nnfs_pkg::SIZE_W-1:0]      csr_wdata
);
   import nnfs_pkg::*;

   cfg_type             cfg;
   queue_status_type    q_stat;
   entry_type           push_entry, pop_entry;
   logic                push, pop;
   logic [2*SIZE_W-1:0] area_check;

   nnfs_csr #(
      .OUT_WIDTH (OUT_WIDTH),
      .OUT_HEIGHT(OUT_HEIGHT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg_o    (cfg)
   );

   nnfs_front #(
      .OUT_WIDTH (OUT_WIDTH),
      .OUT_HEIGHT(OUT_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_pixel_in(req_pixel_in),
      .cfg_i       (cfg),
      .q_stat_i    (q_stat),
      .push_o      (push),
      .entry_o     (push_entry)
   );

   nnfs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (push_entry),
      .pop_i   (pop),
      .data_o  (pop_entry),
      .status_o(q_stat)
   );

   nnfs_back #(
      .OUT_WIDTH (OUT_WIDTH),
      .OUT_HEIGHT(OUT_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat_i     (q_stat),
      .entry_i      (pop_entry),
      .pop_o        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_col  (rsp_out_col),
      .rsp_out_row  (rsp_out_row),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_frame_end(rsp_frame_end)
   );

   // checks
   assign area_check = (2*SIZE_W)'(cfg.width) * (2*SIZE_W)'(cfg.height);

   `NNFS_ASSERT_NOW(a_area_tracks_size, 1'b1, area_check == (2*SIZE_W)'(cfg.area))
   `NNFS_ASSERT_NOW(a_frame_end_pos, rsp_valid && rsp_frame_end, (rsp_out_col == SIZE_W'(OUT_WIDTH - 1)) && (rsp_out_row == SIZE_W'(OUT_HEIGHT - 1)))
   `NNFS_ASSERT_NEXT(a_load_no_result, pop && (pop_entry.kind == KIND_LOAD), !$rose(rsp_valid))
   `NNFS_ASSERT_NOW(a_pop_not_empty, pop, !q_stat.empty)

endmodule

FILE: hw/rtl/nnfs_csr.sv
// Configuration registers of the frame scaler, with size saturation and frame area.
// Depends on nnfs_pkg.
`timescale 1ns / 1ps

module nnfs_csr #(
   parameter int OUT_WIDTH  = nnfs_pkg::OUT_WIDTH_DEFAULT,
   parameter int OUT_HEIGHT = nnfs_pkg::OUT_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [nnfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nnfs_pkg::SIZE_W-1:0]      csr_wdata,
   output nnfs_pkg::cfg_type                cfg_o
);
   import nnfs_pkg::*;

   localparam int WIDTH_LIM  = (OUT_WIDTH < STORE_WIDTH) ? OUT_WIDTH : STORE_WIDTH;
   localparam int HEIGHT_LIM = (OUT_HEIGHT < STORE_HEIGHT) ? OUT_HEIGHT : STORE_HEIGHT;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > lim) r = lim;
      return r;
   endfunction

   logic [SIZE_W-1:0]   width_ff, width_in;
   logic [SIZE_W-1:0]   height_ff, height_in;
   logic                flip_ff, flip_in;
   logic                fill_ff, fill_in;
   logic [ADDR_W-1:0]   area_ff, area_in;
   logic [2*SIZE_W-1:0] area_prod;

   // register writes; the area follows the sizes in the same edge
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      flip_in   = flip_ff;
      fill_in   = fill_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  width_in  = clamp_size(csr_wdata, SIZE_W'(WIDTH_LIM));
            CSR_SOURCE_HEIGHT: height_in = clamp_size(csr_wdata, SIZE_W'(HEIGHT_LIM));
            CSR_FLIP_ROWS:     flip_in   = csr_wdata[0];
            CSR_SCALE_TO_FILL: fill_in   = csr_wdata[0];
            default: ;
         endcase
      end
      area_prod = (2*SIZE_W)'(width_in) * (2*SIZE_W)'(height_in);
      area_in   = area_prod[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(WIDTH_LIM);
         height_ff <= SIZE_W'(HEIGHT_LIM);
         flip_ff   <= 1'b0;
         fill_ff   <= 1'b0;
         area_ff   <= ADDR_W'(WIDTH_LIM * HEIGHT_LIM);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         flip_ff   <= flip_in;
         fill_ff   <= fill_in;
         area_ff   <= area_in;
      end
   end

   assign cfg_o.width  = width_ff;
   assign cfg_o.height = height_ff;
   assign cfg_o.flip   = flip_ff;
   assign cfg_o.fill   = fill_ff;
   assign cfg_o.area   = area_ff;

endmodule

FILE: hw/rtl/nnfs_front.sv
// Front end: takes request beats, keeps the load address and the scan position,
// and pushes classified entries into the queue. Depends on nnfs_pkg.
`timescale 1ns / 1ps

module nnfs_front #(
   parameter int OUT_WIDTH  = nnfs_pkg::OUT_WIDTH_DEFAULT,
   parameter int OUT_HEIGHT = nnfs_pkg::OUT_HEIGHT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [nnfs_pkg::PIXEL_W-1:0] req_pixel_in,
   input  nnfs_pkg::cfg_type            cfg_i,
   input  nnfs_pkg::queue_status_type   q_stat_i,
   output logic                         push_o,
   output nnfs_pkg::entry_type          entry_o
);
   import nnfs_pkg::*;

   localparam int COL_W = $clog2(OUT_WIDTH);
   localparam int ROW_W = $clog2(OUT_HEIGHT);

   logic [COL_W-1:0]  scan_col_ff, scan_col_in;
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [ADDR_W-1:0] load_ff, load_in;
   logic [ADDR_W-1:0] ld_addr, ld_next;
   logic              accept, is_load, col_last, row_last;

   assign req_stall = q_stat_i.full;

   always_comb begin
      accept   = req_valid && !q_stat_i.full;
      is_load  = (req_kind == KIND_LOAD);
      // an address left beyond the frame by a size change restarts at zero
      ld_addr  = (load_ff < cfg_i.area) ? load_ff : '0;
      ld_next  = ld_addr + ADDR_W'(1);
      col_last = (scan_col_ff == COL_W'(OUT_WIDTH - 1));
      row_last = (scan_row_ff == ROW_W'(OUT_HEIGHT - 1));

      load_in     = load_ff;
      scan_col_in = scan_col_ff;
      scan_row_in = scan_row_ff;
      if (accept && is_load) begin
         load_in = (ld_next >= cfg_i.area) ? '0 : ld_next;
      end
      if (accept && !is_load) begin
         if (col_last) begin
            scan_col_in = '0;
            scan_row_in = row_last ? '0 : scan_row_ff + ROW_W'(1);
         end else begin
            scan_col_in = scan_col_ff + COL_W'(1);
         end
      end

      // entry carries a snapshot of the configuration it was taken under
      push_o            = accept;
      entry_o.kind      = req_kind;
      entry_o.pixel     = req_pixel_in;
      entry_o.load_addr = ld_addr;
      entry_o.col       = COORD_W'(scan_col_ff);
      entry_o.row       = COORD_W'(scan_row_ff);
      entry_o.last      = col_last && row_last;
      entry_o.width     = cfg_i.width;
      entry_o.height    = cfg_i.height;
      entry_o.flip      = cfg_i.flip;
      entry_o.fill      = cfg_i.fill;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff     <= '0;
         scan_col_ff <= '0;
         scan_row_ff <= '0;
      end else begin
         load_ff     <= load_in;
         scan_col_ff <= scan_col_in;
         scan_row_ff <= scan_row_in;
      end
   end

endmodule

FILE: hw/rtl/nnfs_queue.sv
// Short queue of classified entries between the front and back ends.
// Depends on nnfs_pkg.
`timescale 1ns / 1ps

module nnfs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_i,
   input  nnfs_pkg::entry_type        data_i,
   input  logic                       pop_i,
   output nnfs_pkg::entry_type        data_o,
   output nnfs_pkg::queue_status_type status_o
);
   import nnfs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_i ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_i ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) count_in = count_ff + CNT_W'(1);
      else if (pop_i && !push_i) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push_i) slots_ff[wr_ptr_ff] <= data_i;
   end

   assign data_o         = slots_ff[rd_ptr_ff];
   assign status_o.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status_o.empty = (count_ff == '0);

endmodule

FILE: hw/rtl/nnfs_back.sv
// Back end: frame store, source coordinate sequencer and the result register.
// Depends on nnfs_pkg.
`timescale 1ns / 1ps

module nnfs_back #(
   parameter int OUT_WIDTH  = nnfs_pkg::OUT_WIDTH_DEFAULT,
   parameter int OUT_HEIGHT = nnfs_pkg::OUT_HEIGHT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nnfs_pkg::queue_status_type   q_stat_i,
   input  nnfs_pkg::entry_type          entry_i,
   output logic                         pop_o,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [nnfs_pkg::SIZE_W-1:0]  rsp_out_col,
   output logic [nnfs_pkg::SIZE_W-1:0]  rsp_out_row,
   output logic [nnfs_pkg::PIXEL_W-1:0] rsp_pixel_out,
   output logic                         rsp_frame_end
);
   import nnfs_pkg::*;

   localparam int COL_W = $clog2(OUT_WIDTH);
   localparam int ROW_W = $clog2(OUT_HEIGHT);
   // products col*w and row*h
   localparam int PC_W  = COL_W + SIZE_W;
   localparam int PR_W  = ROW_W + SIZE_W;
   // reciprocal scale: estimate is exact or one low
   localparam int S_C   = PC_W + SIZE_W;
   localparam int S_R   = PR_W + SIZE_W;
   localparam int MC_W  = S_C - 3;
   localparam int MR_W  = S_R - 3;
   localparam logic [MC_W-1:0] M_C = MC_W'((64'd1 << S_C) / OUT_WIDTH);
   localparam logic [MR_W-1:0] M_R = MR_W'((64'd1 << S_R) / OUT_HEIGHT);
   localparam logic [COL_W:0]  OUT_W_X = (COL_W + 1)'(OUT_WIDTH);
   localparam logic [ROW_W:0]  OUT_H_X = (ROW_W + 1)'(OUT_HEIGHT);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_RECIP = 3'd2;
   localparam logic [2:0] ST_CORR  = 3'd3;
   localparam logic [2:0] ST_PICK  = 3'd4;
   localparam logic [2:0] ST_ADDR  = 3'd5;
   localparam logic [2:0] ST_READ  = 3'd6;
   localparam logic [2:0] ST_SEND  = 3'd7;

   logic [PIXEL_W-1:0] store_mem [STORE_DEPTH];

   logic [2:0]         state_ff, state_in;
   entry_type          cur_ff, cur_in;
   logic [PC_W-1:0]    prod_col_ff, prod_col_in;
   logic [PR_W-1:0]    prod_row_ff, prod_row_in;
   logic [SIZE_W-1:0]  cen_col_ff, cen_col_in;
   logic [SIZE_W-1:0]  cen_row_ff, cen_row_in;
   logic               inside_ff, inside_in;
   logic [SIZE_W-1:0]  q_col_ff, q_col_in;
   logic [SIZE_W-1:0]  q_row_ff, q_row_in;
   logic [SIZE_W-1:0]  src_col_ff, src_col_in;
   logic [SIZE_W-1:0]  src_row_ff, src_row_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [SIZE_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic               rsp_end_ff, rsp_end_in;

   logic [COL_W-1:0]        col_c;
   logic [ROW_W-1:0]        row_c;
   logic [COL_W:0]          col_x, w_x, off_c;
   logic [ROW_W:0]          row_x, h_x, off_r;
   logic                    in_c, in_r;
   logic [PC_W+MC_W-1:0]    recip_col;
   logic [PR_W+MR_W-1:0]    recip_row;
   logic [PC_W-1:0]         rem_col;
   logic [PR_W-1:0]         rem_row;
   logic [SIZE_W-1:0]       pick_row;
   logic [2*SIZE_W-1:0]     addr_full;
   logic                    store_wr, rd_en, taken;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prod_col_in  = prod_col_ff;
      prod_row_in  = prod_row_ff;
      cen_col_in   = cen_col_ff;
      cen_row_in   = cen_row_ff;
      inside_in    = inside_ff;
      q_col_in     = q_col_ff;
      q_row_in     = q_row_ff;
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      addr_in      = addr_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_end_in   = rsp_end_ff;
      pop_o        = 1'b0;
      store_wr     = 1'b0;
      rd_en        = 1'b0;

      // centred window placement
      col_c = cur_ff.col[COL_W-1:0];
      row_c = cur_ff.row[ROW_W-1:0];
      col_x = {1'b0, col_c};
      row_x = {1'b0, row_c};
      w_x   = (COL_W + 1)'(cur_ff.width);
      h_x   = (ROW_W + 1)'(cur_ff.height);
      off_c = (OUT_W_X - w_x) >> 1;
      off_r = (OUT_H_X - h_x) >> 1;
      in_c  = (col_x >= off_c) && (col_x < off_c + w_x);
      in_r  = (row_x >= off_r) && (row_x < off_r + h_x);

      // scaled position: reciprocal estimate, then one correction step
      recip_col = (PC_W + MC_W)'(prod_col_ff) * (PC_W + MC_W)'(M_C);
      recip_row = (PR_W + MR_W)'(prod_row_ff) * (PR_W + MR_W)'(M_R);
      rem_col   = prod_col_ff - PC_W'(q_col_ff) * PC_W'(OUT_WIDTH);
      rem_row   = prod_row_ff - PR_W'(q_row_ff) * PR_W'(OUT_HEIGHT);

      pick_row  = cur_ff.fill ? q_row_ff : cen_row_ff;
      addr_full = (2*SIZE_W)'(src_row_ff) * (2*SIZE_W)'(cur_ff.width)
                  + (2*SIZE_W)'(src_col_ff);

      // result register: free when empty or being taken
      taken        = rsp_valid_ff && !rsp_stall;
      rsp_valid_in = rsp_valid_ff && !taken;

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat_i.empty) begin
               pop_o  = 1'b1;
               cur_in = entry_i;
               if (entry_i.kind == KIND_LOAD) store_wr = 1'b1;
               else state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_col_in = PC_W'(col_c) * PC_W'(cur_ff.width);
            prod_row_in = PR_W'(row_c) * PR_W'(cur_ff.height);
            cen_col_in  = SIZE_W'(col_x - off_c);
            cen_row_in  = SIZE_W'(row_x - off_r);
            inside_in   = cur_ff.fill || (in_c && in_r);
            state_in    = ST_RECIP;
         end
         ST_RECIP: begin
            q_col_in = recip_col[S_C +: SIZE_W];
            q_row_in = recip_row[S_R +: SIZE_W];
            state_in = ST_CORR;
         end
         ST_CORR: begin
            q_col_in = q_col_ff + SIZE_W'(rem_col >= PC_W'(OUT_WIDTH));
            q_row_in = q_row_ff + SIZE_W'(rem_row >= PR_W'(OUT_HEIGHT));
            state_in = ST_PICK;
         end
         ST_PICK: begin
            src_col_in = cur_ff.fill ? q_col_ff : cen_col_ff;
            src_row_in = cur_ff.flip ? cur_ff.height - SIZE_W'(1) - pick_row : pick_row;
            state_in   = ST_ADDR;
         end
         ST_ADDR: begin
            addr_in  = addr_full[ADDR_W-1:0];
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_valid_ff || taken) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = SIZE_W'(cur_ff.col);
               rsp_row_in   = SIZE_W'(cur_ff.row);
               rsp_pixel_in = inside_ff ? rd_data_ff : '0;
               rsp_end_in   = cur_ff.last;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // frame store: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (store_wr) store_mem[entry_i.load_addr] <= entry_i.pixel;
      if (rd_en) rd_data_ff <= store_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prod_col_ff  <= prod_col_in;
      prod_row_ff  <= prod_row_in;
      cen_col_ff   <= cen_col_in;
      cen_row_ff   <= cen_row_in;
      inside_ff    <= inside_in;
      q_col_ff     <= q_col_in;
      q_row_ff     <= q_row_in;
      src_col_ff   <= src_col_in;
      src_row_ff   <= src_row_in;
      addr_ff      <= addr_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

FILE: tb/tb.sv
// Self-checking bench for nearest_neighbor_frame_scaler on its default output raster.
// Depends on nnfs_pkg and the scaler RTL; tracks frame store, load pointer and scan position
// itself, and compares every scanout beat with its own computed pixel.
`timescale 1ns / 1ps

module tb;
   import nnfs_pkg::*;

   // default raster; random geometry stays small so that loads ahead of a scan stay short
   localparam int OUT_W         = OUT_WIDTH_DEFAULT;
   localparam int OUT_H         = OUT_HEIGHT_DEFAULT;
   localparam int W_LIM         = (OUT_W < STORE_WIDTH) ? OUT_W : STORE_WIDTH;
   localparam int H_LIM         = (OUT_H < STORE_HEIGHT) ? OUT_H : STORE_HEIGHT;
   localparam int SMALL_W       = 16;
   localparam int SMALL_H       = 12;
   localparam int BURST_SCANS   = 200;
   localparam int MIXED_ITEMS   = 160;
   localparam int MAX_GAP       = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_LIMIT  = 10;
   localparam int RUN_LIMIT_NS  = 10_000_000;

   typedef struct packed {
      logic [SIZE_W-1:0]  col;
      logic [SIZE_W-1:0]  row;
      logic [PIXEL_W-1:0] pixel;
      logic               frame_end;
   } scan_pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [PIXEL_W-1:0]     req_pixel_in;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SIZE_W-1:0]      rsp_out_col;
   logic [SIZE_W-1:0]      rsp_out_row;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   rsp_frame_end;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [SIZE_W-1:0]      csr_wdata;

   // shadow of the block's registers, store and pointers
   logic [SIZE_W-1:0]  reg_width  = SIZE_W'(1920);
   logic [SIZE_W-1:0]  reg_height = SIZE_W'(1080);
   logic               reg_flip   = 1'b0;
   logic               reg_fill   = 1'b0;
   logic [PIXEL_W-1:0] src_frame [0:STORE_DEPTH-1];
   bit                 src_written [0:STORE_DEPTH-1];
   int                 load_ptr = 0;
   int                 scan_x = 0;
   int                 scan_y = 0;
   scan_pixel_type     pending_pixels[$];

   int error_count   = 0;
   int beats_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // receiver hold-off, counted in the stall process
   int hold_len  = 0;
   bit hold_go   = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   nearest_neighbor_frame_scaler #(
      .OUT_WIDTH  (OUT_W),
      .OUT_HEIGHT (OUT_H)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int lim);
      int x;
      x = v;
      if (x < 1) return 1;
      if (x > lim) return lim;
      return x;
   endfunction

   // store address feeding output pixel (col,row); 0 when it lies outside the centred window
   function automatic bit source_pixel_addr(input int col, input int row, output int addr);
      int w, h, sc, sr, xo, yo;
      w = clamp_dim(reg_width, W_LIM);
      h = clamp_dim(reg_height, H_LIM);
      addr = 0;
      if (reg_fill) begin
         sc = col * w / OUT_W;
         sr = row * h / OUT_H;
      end else begin
         xo = (OUT_W - w) / 2;
         yo = (OUT_H - h) / 2;
         if (col < xo || col >= xo + w || row < yo || row >= yo + h) return 1'b0;
         sc = col - xo;
         sr = row - yo;
      end
      if (reg_flip) sr = h - 1 - sr;
      addr = sr * w + sc;
      return 1'b1;
   endfunction

   // update shadow state for one accepted beat; scanouts queue their pixel
   function automatic void track_beat(input logic kind, input logic [PIXEL_W-1:0] pixel);
      int area, addr;
      scan_pixel_type px;
      area = clamp_dim(reg_width, W_LIM) * clamp_dim(reg_height, H_LIM);
      if (kind == KIND_LOAD) begin
         addr = (load_ptr < area) ? load_ptr : 0;
         src_frame[addr] = pixel;
         src_written[addr] = 1'b1;
         load_ptr = (addr + 1 >= area) ? 0 : addr + 1;
      end else begin
         px.col = SIZE_W'(scan_x);
         px.row = SIZE_W'(scan_y);
         if (source_pixel_addr(scan_x, scan_y, addr)) px.pixel = src_frame[addr];
         else px.pixel = '0;
         px.frame_end = (scan_x == OUT_W - 1) && (scan_y == OUT_H - 1);
         pending_pixels.push_back(px);
         scan_x++;
         if (scan_x >= OUT_W) begin
            scan_x = 0;
            scan_y++;
            if (scan_y >= OUT_H) scan_y = 0;
         end
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : check_rsp
      scan_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("unrequested pixel beat col %0d row %0d",
                                   rsp_out_col, rsp_out_row));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_col != want.col)
               report_error($sformatf("out_col: expected %0d got %0d", want.col, rsp_out_col));
            if (rsp_out_row != want.row)
               report_error($sformatf("out_row: expected %0d got %0d", want.row, rsp_out_row));
            if (rsp_pixel_out != want.pixel)
               report_error($sformatf("pixel_out at (%0d,%0d): expected %04h got %04h",
                                      want.col, want.row, want.pixel, rsp_pixel_out));
            if (rsp_frame_end != want.frame_end)
               report_error($sformatf("frame_end at (%0d,%0d): expected %0b got %0b",
                                      want.col, want.row, want.frame_end, rsp_frame_end));
         end
      end
   end

   // receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic int rand_dim(input int lim);
      case ($urandom_range(4))
         0:       return 0;
         1:       return 1;
         2:       return lim;
         default: return $urandom_range(lim, 1);
      endcase
   endfunction

   // one beat on the request channel, after an optional idle gap
   task automatic send_beat(input logic kind, input logic [PIXEL_W-1:0] pixel);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_pixel_in <= pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_beat(kind, pixel);
      beats_sent++;
   endtask

   // scanout request; loads first if it would read a store entry never written
   task automatic request_pixel();
      int addr;
      while (source_pixel_addr(scan_x, scan_y, addr) && !src_written[addr])
         send_beat(KIND_LOAD, rand_pixel());
      send_beat(KIND_SCAN, PIXEL_W'($urandom));
   endtask

   // stop offering beats, wait for every pixel, then let loads in flight retire
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SIZE_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SOURCE_WIDTH:  reg_width  = SIZE_W'(value);
         CSR_SOURCE_HEIGHT: reg_height = SIZE_W'(value);
         CSR_FLIP_ROWS:     reg_flip   = value[0];
         CSR_SCALE_TO_FILL: reg_fill   = value[0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int w, input int h, input int flip, input int fill);
      write_reg(CSR_SOURCE_WIDTH, w);
      write_reg(CSR_SOURCE_HEIGHT, h);
      write_reg(CSR_FLIP_ROWS, flip);
      write_reg(CSR_SCALE_TO_FILL, fill);
   endtask

   // ---------------------------------------------------------------- tests

   // zero sizes saturate to 1x1; loads wrap onto the single entry
   task automatic test_tiny_source();
      drain();
      set_geometry(0, 0, 1, 1);
      send_beat(KIND_LOAD, 16'hFFFF);
      request_pixel();
      request_pixel();
      send_beat(KIND_LOAD, 16'h0000);
      request_pixel();
      send_beat(KIND_LOAD, 16'h8001);
      request_pixel();
   endtask

   // shrinking the frame below the load pointer restarts loading at zero
   task automatic test_address_restart();
      drain();
      set_geometry(3, 2, 1, 1);
      send_beat(KIND_LOAD, 16'h0000);
      send_beat(KIND_LOAD, 16'hFFFF);
      send_beat(KIND_LOAD, 16'h00FF);
      send_beat(KIND_LOAD, 16'hFF00);
      request_pixel();
      drain();
      set_geometry(2, 1, 1, 1);
      send_beat(KIND_LOAD, 16'h7E7E);
      request_pixel();
   endtask

   // oversize registers saturate to the raster; centred 1x1 leaves black around it
   task automatic test_oversize_source();
      drain();
      set_geometry(2047, 2047, 0, 0);
      repeat (8) request_pixel();
      drain();
      set_geometry(1, 1, 0, 0);
      request_pixel();
   endtask

   // receiver holds off while scan requests pile up behind a waiting pixel
   task automatic test_backpressure();
      drain();
      set_geometry(SMALL_W, SMALL_H, 1, 1);
      send_idle_pct = 0;
      stall_pct     = 0;
      request_pixel();
      hold_len      = 300;
      hold_go      <= ~hold_go;
      repeat (BURST_SCANS) request_pixel();
      drain();
   endtask

   // frame loads, scan runs and loose mixed beats under the current geometry
   task automatic run_mixed_traffic(input int n_items);
      int first, choice, area;
      first = beats_sent;
      while (beats_sent - first < n_items) begin
         choice = $urandom_range(99);
         area = clamp_dim(reg_width, W_LIM) * clamp_dim(reg_height, H_LIM);
         if (choice < 30) begin
            repeat (area) send_beat(KIND_LOAD, rand_pixel());
         end else if (choice < 75) begin
            repeat ($urandom_range(60, 1)) request_pixel();
         end else begin
            repeat ($urandom_range(12, 1)) begin
               if ($urandom_range(1)) request_pixel();
               else send_beat(KIND_LOAD, rand_pixel());
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      int send_idle [4] = '{0, 60, 0, 38};
      int recv_idle [4] = '{0, 0, 60, 38};
      for (int p = 0; p < 4; p++) begin
         for (int s = 0; s < 2; s++) begin
            drain();
            set_geometry(rand_dim(SMALL_W), rand_dim(SMALL_H),
                         $urandom_range(1), $urandom_range(1));
            send_idle_pct = send_idle[p];
            stall_pct     = recv_idle[p];
            run_mixed_traffic(MIXED_ITEMS);
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      req_valid    <= 1'b0;
      req_kind     <= KIND_LOAD;
      req_pixel_in <= '0;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_SOURCE_WIDTH;
      csr_wdata    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_tiny_source();
      test_address_restart();
      test_oversize_source();
      test_backpressure();
      test_random_traffic();

      drain();
      if (error_count == 0) $display("nearest_neighbor_frame_scaler: match");
      else $display("nearest_neighbor_frame_scaler: mismatch");
      $finish;
   end

   // overall run limit
   initial begin
      #RUN_LIMIT_NS;
      $display("nearest_neighbor_frame_scaler: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/nnfs_pkg.sv
hw/rtl/nnfs_csr.sv
hw/rtl/nnfs_front.sv
hw/rtl/nnfs_queue.sv
hw/rtl/nnfs_back.sv
hw/rtl/nearest_neighbor_frame_scaler.sv
tb/tb.sv
